// ----- rtl/bta_pkg.sv -----
// ----------------------------------------------------------------------------
// Block transfer package
// Shared types and codes for the stop-and-wait block transfer engine.
// ----------------------------------------------------------------------------
package bta_pkg;

  localparam int OFF_W   = 15;
  localparam int VER_W   = 16;
  localparam int CNT_W   = 16;
  localparam int TIMER_W = 4;
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = 2;

  localparam int S_TDATA_W = 48;
  localparam int S_TUSER_W = 4;
  localparam int M_TDATA_W = 72;
  localparam int M_TUSER_W = 2;

  localparam logic [TIMER_W-1:0] TIMER_LIMIT   = 4'd8;
  localparam logic [1:0]         RESEND_PHASE  = 2'd3;

  localparam logic REG_IMAGE_SIZE    = 1'b0;
  localparam logic REG_IMAGE_VERSION = 1'b1;

  localparam logic [1:0] MODE_START = 2'd0;
  localparam logic [1:0] MODE_FRAME = 2'd1;
  localparam logic [1:0] MODE_TICK  = 2'd2;
  localparam logic [1:0] MODE_LINK  = 2'd3;

  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_ACK  = 2'd1;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_LAST    = 3'd1;
  localparam logic [2:0] ST_INVALID = 3'd2;
  localparam logic [2:0] ST_VERSION = 3'd3;
  localparam logic [2:0] ST_OFFSET  = 3'd4;
  localparam logic [2:0] ST_UNKNOWN = 3'd5;

  localparam logic [1:0] FR_NONE = 2'd0;
  localparam logic [1:0] FR_DATA = 2'd1;
  localparam logic [1:0] FR_ACK  = 2'd2;

  typedef enum logic [2:0] {
    OP_START,
    OP_DATA,
    OP_ACK,
    OP_UNKNOWN,
    OP_TICK,
    OP_LINK_DOWN
  } op_t;

  typedef struct packed {
    op_t              op;
    logic             ver_ok;
    logic             len_ok;
    logic [OFF_W-1:0] offset;
    logic [OFF_W-1:0] size;
  } item_t;

endpackage

// ----- rtl/bta_front.sv -----
// ----------------------------------------------------------------------------
// Block transfer front end
// Unpacks incoming transfers, decodes the event kind and checks the version.
// ----------------------------------------------------------------------------
module bta_front (
  input  logic [bta_pkg::S_TDATA_W-1:0] s_tdata,
  input  logic [bta_pkg::S_TUSER_W-1:0] s_tuser,
  input  logic [bta_pkg::VER_W-1:0]     image_version,
  output bta_pkg::item_t                item
);
  import bta_pkg::*;

  logic [1:0]       mode;
  logic [1:0]       kind;
  logic [VER_W-1:0] fver;

  assign mode = s_tuser[1:0];
  assign kind = s_tuser[3:2];
  assign fver = s_tdata[16:1];

  always_comb begin
    item.op     = OP_LINK_DOWN;
    item.ver_ok = (fver == image_version);
    item.len_ok = s_tdata[0];
    item.offset = s_tdata[31:17];
    item.size   = s_tdata[46:32];
    case (mode)
      MODE_START: item.op = OP_START;
      MODE_FRAME: begin
        if (kind == KIND_DATA) begin
          item.op = OP_DATA;
        end else if (kind == KIND_ACK) begin
          item.op = OP_ACK;
        end else begin
          item.op = OP_UNKNOWN;
        end
      end
      MODE_TICK:  item.op = OP_TICK;
      MODE_LINK:  item.op = OP_LINK_DOWN;
      default:    item.op = OP_LINK_DOWN;
    endcase
  end

endmodule

// ----- rtl/bta_queue.sv -----
// ----------------------------------------------------------------------------
// Block transfer event queue
// Short first-in first-out queue between the decoder and the execute stage.
// ----------------------------------------------------------------------------
module bta_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  bta_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output bta_pkg::item_t head
);
  import bta_pkg::*;

  item_t             entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_push;
  logic              do_pop;

  assign full      = (count == (QPTR_W+1)'(QDEPTH));
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- rtl/bta_back.sv -----
// ----------------------------------------------------------------------------
// Block transfer execute stage
// Applies one queued event per cycle, while the output is not stalled, to the
// sender and receiver state and holds the result in an output register.
// ----------------------------------------------------------------------------
module bta_back #(
  parameter int BLOCK_BYTES = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  bta_pkg::item_t                in_item,
  output logic                          in_ready,
  input  logic [bta_pkg::OFF_W-1:0]     image_size,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [bta_pkg::M_TDATA_W-1:0] m_tdata,
  output logic [bta_pkg::M_TUSER_W-1:0] m_tuser
);
  import bta_pkg::*;

  localparam logic [OFF_W-1:0] MAX_BLOCK = OFF_W'(BLOCK_BYTES);

  logic [OFF_W-1:0]   send_offset, send_offset_next;
  logic [TIMER_W-1:0] send_timer, send_timer_next;
  logic [OFF_W-1:0]   recv_offset, recv_offset_next;
  logic [OFF_W-1:0]   last_recv_size, last_recv_size_next;
  logic               sending, sending_next;
  logic [CNT_W-1:0]   done_sends, done_sends_next;
  logic [CNT_W-1:0]   done_receives, done_receives_next;

  logic [2:0]       status;
  logic [1:0]       frame_out;
  logic [OFF_W-1:0] out_offset;
  logic [OFF_W-1:0] out_size;
  logic             commit_image;
  logic             went_idle;

  logic [OFF_W:0]     ack_sum;
  logic [OFF_W:0]     data_end;
  logic [OFF_W+1:0]   recv_cont;
  logic [OFF_W-1:0]   recv_base;
  logic [OFF_W-1:0]   emit_from;
  logic [OFF_W-1:0]   emit_left;
  logic               emit_any;
  logic               do_emit;
  logic [TIMER_W-1:0] timer_inc;
  logic               take;

  assign in_ready = !m_tvalid || m_tready;
  assign take     = in_valid && in_ready;

  assign ack_sum   = {1'b0, send_offset} + {1'b0, in_item.size};
  assign data_end  = {1'b0, in_item.offset} + {1'b0, in_item.size};
  assign recv_base = (in_item.offset == '0) ? '0 : recv_offset;
  assign recv_cont = {2'b00, recv_base} + {2'b00, last_recv_size};
  assign timer_inc = send_timer + 1'b1;
  assign emit_any  = (image_size > emit_from);
  assign emit_left = image_size - emit_from;

  always_comb begin
    send_offset_next    = send_offset;
    send_timer_next     = send_timer;
    recv_offset_next    = recv_offset;
    last_recv_size_next = last_recv_size;
    sending_next        = sending;
    done_sends_next     = done_sends;
    done_receives_next  = done_receives;
    status              = ST_OK;
    commit_image        = 1'b0;
    went_idle           = 1'b0;
    do_emit             = 1'b0;
    emit_from           = send_offset;
    frame_out           = FR_NONE;
    out_offset          = '0;
    out_size            = '0;
    case (in_item.op)
      OP_START: begin
        send_offset_next = '0;
        emit_from        = '0;
        do_emit          = 1'b1;
        send_timer_next  = '0;
        sending_next     = 1'b1;
      end
      OP_DATA: begin
        if (!in_item.len_ok) begin
          status = ST_INVALID;
        end else if (!in_item.ver_ok) begin
          status = ST_VERSION;
        end else if (in_item.offset != recv_base &&
                     {2'b00, in_item.offset} != recv_cont) begin
          recv_offset_next = recv_base;
          status           = ST_OFFSET;
        end else begin
          recv_offset_next = in_item.offset;
          if (data_end > {1'b0, image_size}) begin
            status = ST_INVALID;
          end else begin
            if (data_end == {1'b0, image_size}) begin
              done_receives_next = done_receives + 1'b1;
              status             = ST_LAST;
              commit_image       = 1'b1;
            end
            last_recv_size_next = in_item.size;
            frame_out           = FR_ACK;
            out_offset          = in_item.offset;
            out_size            = in_item.size;
          end
        end
      end
      OP_ACK: begin
        if (!in_item.ver_ok) begin
          status = ST_VERSION;
        end else if (in_item.offset != send_offset) begin
          status = ST_INVALID;
        end else begin
          send_offset_next = ack_sum[OFF_W-1:0];
          emit_from        = ack_sum[OFF_W-1:0];
          if (ack_sum >= {1'b0, image_size}) begin
            sending_next    = 1'b0;
            went_idle       = 1'b1;
            done_sends_next = done_sends + 1'b1;
            status          = ST_LAST;
          end else begin
            do_emit         = 1'b1;
            send_timer_next = '0;
          end
        end
      end
      OP_UNKNOWN: status = ST_UNKNOWN;
      OP_TICK: begin
        if (sending) begin
          send_timer_next = timer_inc;
          if (send_timer[1:0] == RESEND_PHASE) begin
            do_emit = 1'b1;
          end else if (timer_inc > TIMER_LIMIT) begin
            sending_next = 1'b0;
            went_idle    = 1'b1;
          end
        end
      end
      OP_LINK_DOWN: begin
        done_sends_next    = '0;
        done_receives_next = '0;
      end
      default: status = ST_OK;
    endcase
    if (do_emit && emit_any) begin
      frame_out  = FR_DATA;
      out_offset = emit_from;
      out_size   = (emit_left >= MAX_BLOCK) ? MAX_BLOCK : emit_left;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      send_offset    <= '0;
      send_timer     <= '0;
      recv_offset    <= '0;
      last_recv_size <= '0;
      sending        <= 1'b0;
      done_sends     <= '0;
      done_receives  <= '0;
      m_tvalid       <= 1'b0;
    end else begin
      if (take) begin
        send_offset    <= send_offset_next;
        send_timer     <= send_timer_next;
        recv_offset    <= recv_offset_next;
        last_recv_size <= last_recv_size_next;
        sending        <= sending_next;
        done_sends     <= done_sends_next;
        done_receives  <= done_receives_next;
        m_tvalid       <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      m_tuser <= frame_out;
      m_tdata <= {4'b0000, done_receives_next, done_sends_next, sending_next,
                  went_idle, commit_image, out_size, out_offset, status};
    end
  end

endmodule

// ----- rtl/block_transfer_ack_retransmit.sv -----
// ----------------------------------------------------------------------------
// Stop-and-wait block transfer engine
// Sender and receiver of a block-by-block image transfer with acknowledgement
// and timed resend.
// ----------------------------------------------------------------------------
// Each input transfer is one event (start, arrived frame, one-second tick or
// link down) and yields exactly one result transfer. The block takes one event
// per cycle while the queue has room: a decoder classifies the event into a
// four-entry queue, and an execute stage applies one event per cycle to the
// transfer state while the output is not stalled, so the rate is set by that
// single-cycle state update, and the result is registered. The image size and
// version registers may be written only while no event is in flight.
module block_transfer_ack_retransmit #(
  parameter int BLOCK_BYTES = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [bta_pkg::VER_W-1:0]     cfg_wdata,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // length_ok, frame_version, frame_offset, frame_size
  input  logic [bta_pkg::S_TDATA_W-1:0] s_tdata,
  // mode, frame_kind
  input  logic [bta_pkg::S_TUSER_W-1:0] s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // status, out_offset, out_size, commit_image, went_idle, busy_res,
  // sent_count, received_count
  output logic [bta_pkg::M_TDATA_W-1:0] m_tdata,
  // frame_out
  output logic [bta_pkg::M_TUSER_W-1:0] m_tuser
);
  import bta_pkg::*;

  logic [OFF_W-1:0] image_size;
  logic [VER_W-1:0] image_version;
  item_t            front_item;
  item_t            queue_head;
  logic             queue_full;
  logic             queue_not_empty;
  logic             back_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_size    <= '0;
      image_version <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_SIZE:    image_size    <= cfg_wdata[OFF_W-1:0];
        REG_IMAGE_VERSION: image_version <= cfg_wdata;
        default:           image_size    <= image_size;
      endcase
    end
  end

  assign s_tready = !queue_full;

  bta_front u_front (
    .s_tdata       (s_tdata),
    .s_tuser       (s_tuser),
    .image_version (image_version),
    .item          (front_item)
  );

  bta_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (s_tvalid),
    .push_item (front_item),
    .full      (queue_full),
    .pop       (back_ready),
    .not_empty (queue_not_empty),
    .head      (queue_head)
  );

  bta_back #(
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (queue_not_empty),
    .in_item    (queue_head),
    .in_ready   (back_ready),
    .image_size (image_size),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser)
  );

endmodule

// ----- tb/tb_block_transfer_ack_retransmit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the stop-and-wait block transfer engine
// Drives start, frame, tick and link-down events into the stream input and
// checks every result against a cycle-free predictor of the send and receive
// state. A directed part hits resend, give-up, idle acks, bad versions,
// offsets and lengths and the field extremes. A random part then runs
// well-formed send and receive sequences mixed with noise under several
// register settings, with random stalls on both stream sides.
// ----------------------------------------------------------------------------
module tb_block_transfer_ack_retransmit;
  import bta_pkg::*;

  localparam int BLOCK          = 256;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 6;
  localparam int RANDOM_ITEMS   = 500;
  localparam int PHASE_ITEMS    = 50;

  localparam logic [1:0] KIND_UNKNOWN = 2'd2;
  localparam logic [1:0] KIND_SPARE   = 2'd3;

  typedef struct packed {
    logic [1:0]  mode;
    logic [1:0]  kind;
    logic        len_ok;
    logic [15:0] version;
    logic [14:0] offset;
    logic [14:0] size;
  } evt_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [1:0]  frame_out;
    logic [14:0] out_offset;
    logic [14:0] out_size;
    logic        commit;
    logic        went_idle;
    logic        busy;
    logic [15:0] sent_count;
    logic [15:0] received_count;
  } reply_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic [3:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;
  logic [1:0]  m_tuser;

  // Predictor copy of the registers and the transfer state.
  logic [14:0] cfg_size = '0;
  logic [15:0] cfg_version = '0;
  logic [14:0] snd_off = '0;
  logic [3:0]  snd_timer = '0;
  logic [14:0] rcv_off = '0;
  logic [14:0] rcv_last = '0;
  logic        snd_active = 1'b0;
  logic [15:0] n_sent = '0;
  logic [15:0] n_recv = '0;

  reply_t reply_queue[$];

  logic calm = 1'b0;
  int   n_items = 0;
  int   n_directed = 0;
  int   n_checked = 0;
  int   n_configs = 0;
  int   n_errors = 0;
  int   stall_cycles = 0;

  block_transfer_ack_retransmit #(.BLOCK_BYTES(BLOCK)) u_top (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic reply_t with_block(reply_t r);
    logic [15:0] left;
    if (cfg_size > snd_off) begin
      left = {1'b0, cfg_size} - {1'b0, snd_off};
      r.frame_out  = FR_DATA;
      r.out_offset = snd_off;
      r.out_size   = (left >= BLOCK) ? 15'(BLOCK) : left[14:0];
    end
    return r;
  endfunction

  task automatic apply_event(input evt_t e, output reply_t r);
    logic [16:0] sum;
    logic [3:0]  old_timer;
    logic        cont;
    r = '0;
    r.status = ST_OK;
    r.frame_out = FR_NONE;
    case (e.mode)
      MODE_START: begin
        snd_off = '0;
        r = with_block(r);
        snd_timer = '0;
        snd_active = 1'b1;
      end
      MODE_FRAME: begin
        if (e.kind == KIND_DATA) begin
          if (!e.len_ok) begin
            r.status = ST_INVALID;
          end else if (e.version != cfg_version) begin
            r.status = ST_VERSION;
          end else begin
            cont = 1'b1;
            if (e.offset == '0) rcv_off = '0;
            if (e.offset != rcv_off) begin
              if ({2'b0, e.offset} == {2'b0, rcv_off} + {2'b0, rcv_last}) begin
                rcv_off = e.offset;
              end else begin
                r.status = ST_OFFSET;
                cont = 1'b0;
              end
            end
            if (cont) begin
              sum = {2'b0, e.offset} + {2'b0, e.size};
              if (sum > {2'b0, cfg_size}) begin
                r.status = ST_INVALID;
              end else begin
                if (sum == {2'b0, cfg_size}) begin
                  n_recv = n_recv + 16'd1;
                  r.status = ST_LAST;
                  r.commit = 1'b1;
                end
                rcv_last = e.size;
                r.frame_out = FR_ACK;
                r.out_offset = e.offset;
                r.out_size = e.size;
              end
            end
          end
        end else if (e.kind == KIND_ACK) begin
          if (e.version != cfg_version) begin
            r.status = ST_VERSION;
          end else if (e.offset != snd_off) begin
            r.status = ST_INVALID;
          end else begin
            sum = {2'b0, snd_off} + {2'b0, e.size};
            snd_off = sum[14:0];
            if (sum >= {2'b0, cfg_size}) begin
              snd_active = 1'b0;
              r.went_idle = 1'b1;
              n_sent = n_sent + 16'd1;
              r.status = ST_LAST;
            end else begin
              r = with_block(r);
              snd_timer = '0;
            end
          end
        end else begin
          r.status = ST_UNKNOWN;
        end
      end
      MODE_TICK: begin
        if (snd_active) begin
          old_timer = snd_timer;
          snd_timer = snd_timer + 4'd1;
          if (old_timer[1:0] == RESEND_PHASE) begin
            r = with_block(r);
          end else if (snd_timer > TIMER_LIMIT) begin
            snd_active = 1'b0;
            r.went_idle = 1'b1;
          end
        end
      end
      MODE_LINK: begin
        n_sent = '0;
        n_recv = '0;
      end
    endcase
    r.busy = snd_active;
    r.sent_count = n_sent;
    r.received_count = n_recv;
  endtask

  // Called and returning at a falling edge.
  task automatic send_event(input logic [1:0] mode, input logic [1:0] kind,
                            input logic len_ok, input logic [15:0] ver,
                            input logic [14:0] off, input logic [14:0] size);
    evt_t   e;
    reply_t r;
    e = {mode, kind, len_ok, ver, off, size};
    while (!calm && $urandom_range(99) < 32) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= {kind, mode};
    s_tdata <= {1'b0, size, off, ver, len_ok};
    do @(posedge clk); while (!s_tready);
    apply_event(e, r);
    reply_queue.push_back(r);
    n_items++;
    @(negedge clk);
  endtask

  task automatic fire_ctrl(input logic [1:0] mode);
    send_event(mode, 2'($urandom), 1'($urandom), 16'($urandom), 15'($urandom),
               15'($urandom));
  endtask

  task automatic fire_random();
    send_event(2'($urandom), 2'($urandom), 1'($urandom), 16'($urandom),
               15'($urandom), 15'($urandom));
  endtask

  task automatic send_ack(input logic [15:0] ver, input logic [14:0] off,
                          input logic [14:0] size);
    send_event(MODE_FRAME, KIND_ACK, 1'($urandom), ver, off, size);
  endtask

  task automatic send_data(input logic len_ok, input logic [15:0] ver,
                           input logic [14:0] off, input logic [14:0] size);
    send_event(MODE_FRAME, KIND_DATA, len_ok, ver, off, size);
  endtask

  function automatic logic [15:0] other_version();
    return cfg_version ^ (16'h1 << $urandom_range(15));
  endfunction

  function automatic logic [14:0] send_block_len();
    logic [15:0] left;
    left = (cfg_size > snd_off) ? {1'b0, cfg_size} - {1'b0, snd_off} : 16'd0;
    return (left >= BLOCK) ? 15'(BLOCK) : left[14:0];
  endfunction

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (reply_queue.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    if (idx == REG_IMAGE_SIZE) cfg_size = value[14:0];
    else cfg_version = value;
  endtask

  task automatic set_config(input logic [14:0] size, input logic [15:0] ver);
    wait_idle();
    write_reg(REG_IMAGE_SIZE, {1'($urandom), size});
    write_reg(REG_IMAGE_VERSION, ver);
    cfg_we <= 1'b0;
    n_configs++;
    @(negedge clk);
  endtask

  task automatic test_send_path();
    set_config(15'd600, 16'hA5A5);
    fire_ctrl(MODE_START);
    send_ack(16'h5AA5, 15'd0, 15'd256);
    send_ack(16'hA5A5, 15'd100, 15'd256);
    send_ack(16'hA5A5, 15'd0, 15'd256);
    // Resends on the fourth and eighth tick, gives up on the ninth.
    repeat (9) fire_ctrl(MODE_TICK);
    // Acks still apply after giving up.
    send_ack(16'hA5A5, 15'd256, 15'd256);
    send_ack(16'hA5A5, 15'd512, 15'd88);
  endtask

  task automatic test_receive_path();
    send_data(1'b0, 16'hA5A5, 15'd0, 15'd300);
    send_data(1'b1, 16'h5A5A, 15'd0, 15'd300);
    send_data(1'b1, 16'hA5A5, 15'd0, 15'd300);
    send_data(1'b1, 16'hA5A5, 15'd450, 15'd100);
    send_data(1'b1, 16'hA5A5, 15'd300, 15'd300);
    send_data(1'b1, 16'hA5A5, 15'd0, 15'd700);
    send_event(MODE_FRAME, KIND_UNKNOWN, 1'b1, 16'hA5A5, 15'd0, 15'd0);
    send_event(MODE_FRAME, KIND_SPARE, 1'b0, 16'hFFFF, 15'h7FFF, 15'h7FFF);
  endtask

  task automatic test_extremes();
    set_config(15'd0, 16'h0000);
    fire_ctrl(MODE_START);
    set_config(15'h7FFF, 16'hFFFF);
    fire_ctrl(MODE_START);
    send_ack(16'hFFFF, 15'd0, 15'h7FFF);
    send_data(1'b1, 16'hFFFF, 15'd0, 15'h7FFF);
    send_data(1'b1, 16'hFFFF, 15'h7FFF, 15'h7FFF);
    fire_ctrl(MODE_LINK);
  endtask

  task automatic seq_send();
    int          k;
    int          steps;
    int          pick;
    logic [14:0] blk;
    fire_ctrl(MODE_START);
    steps = $urandom_range(14, 4);
    for (k = 0; k < steps && snd_active; k++) begin
      blk = send_block_len();
      pick = $urandom_range(15);
      if (pick < 9) send_ack(cfg_version, snd_off, blk);
      else if (pick < 11) fire_ctrl(MODE_TICK);
      else if (pick == 11) send_ack(other_version(), snd_off, blk);
      else if (pick == 12) send_ack(cfg_version, 15'($urandom), blk);
      else if (pick == 13) send_ack(cfg_version, snd_off, 15'($urandom));
      else if (pick == 14) send_ack(cfg_version, snd_off, 15'($urandom_range(blk)));
      else fire_random();
    end
  endtask

  task automatic seq_receive();
    int          k;
    int          steps;
    int          pick;
    logic        restart;
    logic [16:0] nxt;
    logic [15:0] left;
    logic [14:0] off;
    logic [14:0] cap;
    logic [14:0] sz;
    restart = 1'b1;
    steps = $urandom_range(12, 3);
    for (k = 0; k < steps; k++) begin
      nxt = {2'b0, rcv_off} + {2'b0, rcv_last};
      if (restart || nxt > 17'd32767 || $urandom_range(9) == 0) off = '0;
      else if ($urandom_range(9) == 0) off = rcv_off;
      else off = nxt[14:0];
      restart = 1'b0;
      left = (cfg_size > off) ? {1'b0, cfg_size} - {1'b0, off} : 16'd0;
      cap = (left >= BLOCK) ? 15'(BLOCK) : left[14:0];
      if (cap == '0) sz = '0;
      else if ($urandom_range(1)) sz = cap;
      else sz = 15'($urandom_range(cap, 1));
      pick = $urandom_range(11);
      if (pick == 0) begin
        send_data(1'b0, cfg_version, off, sz);
      end else if (pick == 1) begin
        send_data(1'b1, other_version(), off, sz);
      end else if (pick == 2) begin
        send_data(1'b1, cfg_version, 15'($urandom), sz);
      end else if (pick == 3) begin
        send_data(1'b1, cfg_version, off, 15'($urandom));
      end else begin
        send_data(1'b1, cfg_version, off, sz);
        if ({1'b0, off} + {1'b0, sz} == {1'b0, cfg_size}) restart = 1'b1;
      end
    end
  endtask

  task automatic seq_tick_storm();
    int k;
    int n;
    if (!snd_active || $urandom_range(1)) fire_ctrl(MODE_START);
    n = $urandom_range(12, 6);
    for (k = 0; k < n; k++) begin
      if ($urandom_range(15) == 0) fire_ctrl(MODE_LINK);
      else fire_ctrl(MODE_TICK);
    end
  endtask

  task automatic test_random_traffic();
    int          stop_at;
    int          next_cfg;
    int          phase;
    int          pick;
    logic [14:0] size;
    logic [15:0] ver;
    stop_at = n_items + RANDOM_ITEMS;
    phase = 0;
    while (n_items < stop_at) begin
      pick = $urandom_range(9);
      if (pick == 0) size = '0;
      else if (pick == 1) size = 15'h7FFF;
      else if (pick == 2) size = 15'(BLOCK);
      else if (pick == 3) size = 15'(BLOCK + 1);
      else if (pick == 4) size = 15'd1;
      else size = 15'($urandom_range(1500, 1));
      pick = $urandom_range(5);
      if (pick == 0) ver = 16'h0000;
      else if (pick == 1) ver = 16'hFFFF;
      else ver = 16'($urandom);
      set_config(size, ver);
      calm = (phase == 3);
      next_cfg = n_items + PHASE_ITEMS;
      while (n_items < next_cfg && n_items < stop_at) begin
        pick = $urandom_range(9);
        if (pick < 4) seq_send();
        else if (pick < 7) seq_receive();
        else if (pick == 7) seq_tick_storm();
        else repeat ($urandom_range(6, 3)) fire_random();
      end
      phase++;
    end
    calm = 1'b0;
  endtask

  always @(negedge clk) begin
    m_tready <= calm || ($urandom_range(99) >= 32);
  end

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      n_errors++;
    end
  endtask

  always @(posedge clk) begin : check_replies
    reply_t want;
    reply_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.status         = m_tdata[2:0];
      got.out_offset     = m_tdata[17:3];
      got.out_size       = m_tdata[32:18];
      got.commit         = m_tdata[33];
      got.went_idle      = m_tdata[34];
      got.busy           = m_tdata[35];
      got.sent_count     = m_tdata[51:36];
      got.received_count = m_tdata[67:52];
      got.frame_out      = m_tuser;
      if (reply_queue.size() == 0) begin
        $error("result transfer arrived with no result expected");
        n_errors++;
      end else begin
        want = reply_queue.pop_front();
        n_checked++;
        check_field("status", 16'(want.status), 16'(got.status));
        check_field("frame_out", 16'(want.frame_out), 16'(got.frame_out));
        check_field("out_offset", 16'(want.out_offset), 16'(got.out_offset));
        check_field("out_size", 16'(want.out_size), 16'(got.out_size));
        check_field("commit_image", 16'(want.commit), 16'(got.commit));
        check_field("went_idle", 16'(want.went_idle), 16'(got.went_idle));
        check_field("busy_res", 16'(want.busy), 16'(got.busy));
        check_field("sent_count", want.sent_count, got.sent_count);
        check_field("received_count", want.received_count, got.received_count);
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired with %0d results outstanding.", reply_queue.size());
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_send_path();
    test_receive_path();
    test_extremes();
    n_directed = n_items;
    test_random_traffic();
    wait_idle();
    $display("Sent %0d events (%0d directed) under %0d register settings.",
             n_items, n_directed, n_configs);
    $display("Checked %0d results covering send, resend, give-up and receive paths.",
             n_checked);
    if (n_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
